/* rtl/sft_pkg.sv */
// Shared constants, command codes and controller/datapath struct types.
// No dependencies; used by every module of the shading frame transform.
package sft_pkg;
    localparam int CompWidth = 16;
    localparam int FracBits  = 14;
    localparam int CrossW    = 2 * CompWidth + 2;
    localparam int MagW      = 31;
    localparam int SqW       = 64;
    localparam int RootW     = 32;
    localparam int QuoW      = MagW + FracBits + 1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_W2L  = 2'd1;
    localparam logic [1:0] CMD_L2W  = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_CAP    = 4'd1;
    localparam logic [3:0] OP_MAC    = 4'd2;
    localparam logic [3:0] OP_CROSS  = 4'd3;
    localparam logic [3:0] OP_NORM   = 4'd4;
    localparam logic [3:0] OP_SQ     = 4'd5;
    localparam logic [3:0] OP_ROOT   = 4'd6;
    localparam logic [3:0] OP_DIVI   = 4'd7;
    localparam logic [3:0] OP_DIV    = 4'd8;
    localparam logic [3:0] OP_STORE  = 4'd9;
    localparam logic [3:0] OP_RES    = 4'd10;
    localparam logic [3:0] OP_ZERO   = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] idx;    // component / term index
        logic       second; // working on tangent B
    } t_cmd;

    typedef struct packed {
        logic       zero_len;
        logic       norm_done;
        logic       root_done;
        logic       div_done;
        logic [1:0] cmd;
    } t_stat;
endpackage

/* rtl/sft_datapath.sv */
// Datapath: frame registers, MAC multipliers, cross/normalise units.
// Depends on sft_pkg.
module sft_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sft_pkg::t_cmd                    i_cmd,
    input  logic [1:0]                       i_in_cmd,
    input  logic signed [sft_pkg::CompWidth-1:0] i_vx,
    input  logic signed [sft_pkg::CompWidth-1:0] i_vy,
    input  logic signed [sft_pkg::CompWidth-1:0] i_vz,
    output sft_pkg::t_stat                   o_stat,
    output logic signed [sft_pkg::CompWidth-1:0] o_rx,
    output logic signed [sft_pkg::CompWidth-1:0] o_ry,
    output logic signed [sft_pkg::CompWidth-1:0] o_rz,
    output logic                             o_degen
);
    localparam int W  = sft_pkg::CompWidth;
    localparam int CW = sft_pkg::CrossW;
    localparam int AW = W + 4;
    localparam int MW = sft_pkg::MagW;
    localparam int QW = sft_pkg::QuoW;

    logic signed [W-1:0] r_n [3];
    logic signed [W-1:0] r_a [3];
    logic signed [W-1:0] r_b [3];
    logic signed [W-1:0] r_v [3];
    logic [1:0]          r_c;
    logic signed [AW-1:0] r_acc [3];
    logic signed [CW-1:0] r_cr [3];
    logic [sft_pkg::MagW-1:0] r_m [3];
    logic [2:0]           r_neg;
    logic [sft_pkg::SqW-1:0] r_sq;
    logic [sft_pkg::SqW-1:0] r_rem;
    logic [sft_pkg::SqW-1:0] r_root;
    logic [5:0]           r_rcnt;
    logic [sft_pkg::QuoW-1:0] r_num;
    logic [sft_pkg::QuoW-1:0] r_quo;
    logic [sft_pkg::RootW:0]  r_drem;
    logic [5:0]           r_dcnt;
    logic signed [W-1:0]  r_t [3];
    logic                 r_degen;
    logic                 r_nd;
    logic signed [W-1:0]  r_o [3];

    function automatic logic signed [W-1:0] f_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        hi = AW'((64'sd1 <<< (W-1)) - 1);
        lo = -AW'(64'sd1 <<< (W-1));
        if (v > hi) return W'(hi);
        if (v < lo) return W'(lo);
        return W'(v);
    endfunction

    // first product of each MAC step (tangent A term)
    logic signed [W-1:0]   m_a, m_b;
    logic signed [2*W-1:0] m_p;
    logic signed [2*W-sft_pkg::FracBits-1:0] m_s;
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            sft_pkg::OP_MAC: begin
                if (r_c == sft_pkg::CMD_W2L) begin
                    m_a = r_v[i_cmd.idx];
                    m_b = r_a[i_cmd.idx];
                end else begin
                    m_a = r_a[i_cmd.idx];
                    m_b = r_v[0];
                end
            end
            default: ;
        endcase
        m_p = m_a * m_b;
        m_s = m_p[2*W-1:sft_pkg::FracBits];
    end

    // second product of each row/column uses B, third uses N (sequenced over MAC steps)
    logic signed [2*W-1:0] p_b, p_n;
    logic signed [2*W-sft_pkg::FracBits-1:0] s_b, s_n;
    always_comb begin
        if (r_c == sft_pkg::CMD_W2L) begin
            p_b = r_v[i_cmd.idx] * r_b[i_cmd.idx];
            p_n = r_v[i_cmd.idx] * r_n[i_cmd.idx];
        end else begin
            p_b = r_b[i_cmd.idx] * r_v[1];
            p_n = r_n[i_cmd.idx] * r_v[2];
        end
        s_b = p_b[2*W-1:sft_pkg::FracBits];
        s_n = p_n[2*W-1:sft_pkg::FracBits];
    end

    // cross product of N with helper (first) or with A (second)
    function automatic logic signed [CW-1:0] f_fm(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b;
        return CW'(p >>> sft_pkg::FracBits);
    endfunction

    logic signed [W-1:0] hx, hy, hz;
    logic signed [CW-1:0] cx, cy, cz;
    always_comb begin
        if (!i_cmd.second) begin
            hx = '0;
            hy = (r_n[2] != '0) ? -W'(1 << sft_pkg::FracBits) : '0;
            hz = (r_n[2] != '0) ? '0 : -W'(1 << sft_pkg::FracBits);
        end else begin
            hx = r_a[0];
            hy = r_a[1];
            hz = r_a[2];
        end
        cx = f_fm(r_n[1], hz) - f_fm(r_n[2], hy);
        cy = f_fm(r_n[2], hx) - f_fm(r_n[0], hz);
        cz = f_fm(r_n[0], hy) - f_fm(r_n[1], hx);
    end

    // magnitude scaling to put the largest in [2^29, 2^30)
    logic [CW-1:0] mg [3];
    logic [CW-1:0] mx;
    logic [5:0]    lz;
    always_comb begin
        for (int i = 0; i < 3; i++)
            mg[i] = r_cr[i][CW-1] ? CW'(-r_cr[i]) : CW'(r_cr[i]);
        mx = mg[0];
        if (mg[1] > mx) mx = mg[1];
        if (mg[2] > mx) mx = mg[2];
        lz = '0;
        for (int k = 0; k < CW; k++)
            if (mx[k]) lz = 6'(k);
    end

    // root register holds the full-width running value of the digit recurrence
    logic [sft_pkg::SqW-1:0] sq_t;
    logic [sft_pkg::SqW-1:0] trial;
    logic [sft_pkg::SqW-1:0] bitv;
    logic [sft_pkg::RootW:0] dsh;
    always_comb begin
        sq_t = 64'(r_m[i_cmd.idx]) * 64'(r_m[i_cmd.idx]);
        bitv = 64'd1 << (7'd62 - {r_rcnt, 1'b0});
        trial = r_root + bitv;
        dsh = {r_drem[sft_pkg::RootW-1:0], r_num[sft_pkg::QuoW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= '0;
                r_a[i] <= '0;
                r_b[i] <= '0;
            end
            r_c <= '0;
            r_degen <= 1'b0;
            r_nd <= 1'b0;
            r_rcnt <= '0;
            r_dcnt <= '0;
        end else begin
            case (i_cmd.op)
                sft_pkg::OP_CAP: begin
                    r_v[0] <= i_vx;
                    r_v[1] <= i_vy;
                    r_v[2] <= i_vz;
                    r_c <= i_in_cmd;
                    r_degen <= 1'b0;
                    for (int i = 0; i < 3; i++)
                        r_acc[i] <= '0;
                    if (i_in_cmd == sft_pkg::CMD_LOAD) begin
                        r_n[0] <= i_vx;
                        r_n[1] <= i_vy;
                        r_n[2] <= i_vz;
                    end
                end
                sft_pkg::OP_MAC: begin
                    // world to local: step k adds input component k to all three rows
                    if (r_c == sft_pkg::CMD_W2L) begin
                        r_acc[0] <= r_acc[0] + AW'(m_s);
                        r_acc[1] <= r_acc[1] + AW'(s_b);
                        r_acc[2] <= r_acc[2] + AW'(s_n);
                    end else begin
                        r_acc[i_cmd.idx] <= r_acc[i_cmd.idx] + AW'(m_s) + AW'(s_b)
                                            + AW'(s_n);
                    end
                end
                sft_pkg::OP_CROSS: begin
                    r_cr[0] <= cx;
                    r_cr[1] <= cy;
                    r_cr[2] <= cz;
                end
                sft_pkg::OP_NORM: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_cr[i][CW-1];
                        if (lz >= 6'd29)
                            r_m[i] <= MW'(mg[i] >> (lz - 6'd29));
                        else
                            r_m[i] <= MW'(mg[i] << (6'd29 - lz));
                    end
                    r_nd <= (mx == '0);
                    r_sq <= '0;
                end
                sft_pkg::OP_SQ: begin
                    r_sq <= r_sq + sq_t;
                    r_rem <= r_sq + sq_t;
                    r_root <= '0;
                    r_rcnt <= '0;
                end
                sft_pkg::OP_ROOT: begin
                    // one result bit per cycle
                    if (r_rem >= trial) begin
                        r_rem <= r_rem - trial;
                        r_root <= (r_root >> 1) + bitv;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_rcnt <= r_rcnt + 6'd1;
                end
                sft_pkg::OP_DIVI: begin
                    r_num <= QW'(({15'd0, r_m[i_cmd.idx]} << sft_pkg::FracBits)
                             + QW'(r_root >> 1));
                    r_drem <= '0;
                    r_quo <= '0;
                    r_dcnt <= '0;
                end
                sft_pkg::OP_DIV: begin
                    r_num <= r_num << 1;
                    if (dsh >= {1'b0, r_root[sft_pkg::RootW-1:0]}) begin
                        r_drem <= dsh - {1'b0, r_root[sft_pkg::RootW-1:0]};
                        r_quo <= {r_quo[sft_pkg::QuoW-2:0], 1'b1};
                    end else begin
                        r_drem <= dsh;
                        r_quo <= {r_quo[sft_pkg::QuoW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 6'd1;
                end
                sft_pkg::OP_STORE: begin
                    if (r_quo > QW'((1 << (W-1)) - 1))
                        r_t[i_cmd.idx] <= r_neg[i_cmd.idx] ? W'(1 << (W-1))
                                                           : W'((1 << (W-1)) - 1);
                    else
                        r_t[i_cmd.idx] <= r_neg[i_cmd.idx] ? -W'(r_quo) : W'(r_quo);
                end
                sft_pkg::OP_ZERO: begin
                    for (int i = 0; i < 3; i++) r_t[i] <= '0;
                    r_degen <= 1'b1;
                end
                sft_pkg::OP_RES: begin
                    if (r_c == sft_pkg::CMD_LOAD) begin
                        if (!i_cmd.second) begin
                            for (int i = 0; i < 3; i++) r_a[i] <= r_t[i];
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_b[i] <= r_t[i];
                                r_o[i] <= r_a[i];
                            end
                        end
                    end else if (r_c == sft_pkg::CMD_W2L || r_c == sft_pkg::CMD_L2W) begin
                        for (int i = 0; i < 3; i++) r_o[i] <= f_sat(r_acc[i]);
                    end else begin
                        for (int i = 0; i < 3; i++) r_o[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.zero_len  = r_nd;
    assign o_stat.norm_done = 1'b1;
    assign o_stat.root_done = (r_rcnt == 6'd31);
    assign o_stat.div_done  = (r_dcnt == 6'(sft_pkg::QuoW - 1));
    assign o_stat.cmd       = r_c;
    assign o_rx = r_o[0];
    assign o_ry = r_o[1];
    assign o_rz = r_o[2];
    assign o_degen = r_degen && (r_c == sft_pkg::CMD_LOAD);
endmodule

/* rtl/sft_ctrl.sv */
// Controller state machine sequencing the datapath for each command.
// Depends on sft_pkg.
module sft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  sft_pkg::t_stat i_stat,
    output sft_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_MAC   = 4'd2;
    localparam logic [3:0] S_CROSS = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_STORE = 4'd9;
    localparam logic [3:0] S_RES   = 4'd10;
    localparam logic [3:0] S_ZERO  = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       r_sec, n_sec;
    logic       r_ov, n_ov;

    // accept a new transaction only while idle, and then only if no result is held or the held result leaves
    logic take;
    assign take = (r_state == S_IDLE) && (!r_ov || !i_stall);
    assign o_stall = !take;
    assign o_valid = r_ov;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_sec = r_sec;
        n_ov = r_ov && i_stall;
        o_cmd.op = sft_pkg::OP_NONE;
        o_cmd.idx = r_idx;
        o_cmd.second = r_sec;
        case (r_state)
            S_IDLE: begin
                if (take && i_valid) begin
                    o_cmd.op = sft_pkg::OP_CAP;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_idx = '0;
                n_sec = 1'b0;
                if (i_stat.cmd == sft_pkg::CMD_LOAD) n_state = S_CROSS;
                else if (i_stat.cmd == sft_pkg::CMD_W2L ||
                         i_stat.cmd == sft_pkg::CMD_L2W) n_state = S_MAC;
                else n_state = S_RES;
            end
            S_MAC: begin
                o_cmd.op = sft_pkg::OP_MAC;
                n_idx = r_idx + 2'd1;
                if (r_idx == 2'd2) n_state = S_RES;
            end
            S_CROSS: begin
                o_cmd.op = sft_pkg::OP_CROSS;
                n_state = S_NORM;
            end
            S_NORM: begin
                o_cmd.op = sft_pkg::OP_NORM;
                n_state = S_SQ;
                n_idx = '0;
            end
            S_SQ: begin
                if (i_stat.zero_len) n_state = S_ZERO;
                else begin
                    o_cmd.op = sft_pkg::OP_SQ;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd2) begin
                        n_state = S_ROOT;
                        n_idx = '0;
                    end
                end
            end
            S_ROOT: begin
                o_cmd.op = sft_pkg::OP_ROOT;
                if (i_stat.root_done) n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.op = sft_pkg::OP_DIVI;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = sft_pkg::OP_DIV;
                if (i_stat.div_done) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.op = sft_pkg::OP_STORE;
                n_idx = r_idx + 2'd1;
                n_state = (r_idx == 2'd2) ? S_RES : S_DIVI;
            end
            S_ZERO: begin
                o_cmd.op = sft_pkg::OP_ZERO;
                n_state = S_RES;
            end
            S_RES: begin
                o_cmd.op = sft_pkg::OP_RES;
                if (i_stat.cmd == sft_pkg::CMD_LOAD && !r_sec) begin
                    n_sec = 1'b1;
                    n_state = S_CROSS;
                end else begin
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_sec <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_sec <= n_sec;
            r_ov <= n_ov;
        end
    end
endmodule

/* rtl/shading_frame_transform_core.sv */
// Top level of the shading frame transform: controller plus datapath.
// Depends on sft_pkg, sft_ctrl and sft_datapath.
//
// Use: input transactions carry i_cmd and a Q1.14 vector on i_vec_x/y/z,
// taken when i_valid is high and o_stall is low. Results leave on o_out_x/y/z
// and o_degenerate with o_valid, taken when i_stall is low.
// Sequence after acceptance: world-to-local and local-to-world run decode,
// three multiply-accumulate steps, then result.
// Load: decode then two passes (cross, scale, three squares, 32
// square-root steps, then per component one setup step, 46 restoring-divide
// steps and a store, then result). A zero-length pass skips the squares,
// root and divide, and zeroes the tangent before its result.
// Unknown commands: decode then result, which is zero.
// One transaction is in flight at a time; a new one is taken once the
// controller is idle and the result register is free or is being read
// in the same cycle.
// Reset clears the frame to zeros and empties the result register.
// While the receiver stalls the result holds and no new work starts.
module shading_frame_transform_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic signed [15:0] i_vec_x,
    input  logic signed [15:0] i_vec_y,
    input  logic signed [15:0] i_vec_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic        o_degenerate
);
    sft_pkg::t_cmd  w_cmd;
    sft_pkg::t_stat w_stat;

    sft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sft_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_in_cmd (i_cmd),
        .i_vx     (i_vec_x),
        .i_vy     (i_vec_y),
        .i_vz     (i_vec_z),
        .o_stat   (w_stat),
        .o_rx     (o_out_x),
        .o_ry     (o_out_y),
        .o_rz     (o_out_z),
        .o_degen  (o_degenerate)
    );

    // a held result stays put while stalled (x and z are checked)
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_z))
        else $error("result changed under stall");
    // degenerate only flagged for loads
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> w_stat.cmd == sft_pkg::CMD_LOAD)
        else $error("degenerate on transform");
    // no input taken while a stalled result would be overwritten
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("accept while result blocked");
endmodule

/* tb/sv/shading_frame_transform_core_tb.sv */
// Self-checking testbench for shading_frame_transform_core: drives command
// transactions, predicts each result with its own frame model, checks outputs.
// Depends on sft_pkg and the shading_frame_transform_core RTL.

class frame_scoreboard;
    // Frame state held by the predictor
    longint nrm[3];
    longint tan_a[3];
    longint tan_b[3];
    // Expected results, oldest first: {x, y, z, degenerate}
    logic [48:0] pending[$];
    int unsigned n_err;
    int unsigned n_ok;
    int unsigned n_load;
    int unsigned n_degen;

    function new();
        for (int i = 0; i < 3; i++) begin
            nrm[i] = 0;
            tan_a[i] = 0;
            tan_b[i] = 0;
        end
        n_err = 0;
        n_ok = 0;
        n_load = 0;
        n_degen = 0;
    endfunction

    // Floor shift of a fixed-point product
    function longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> sft_pkg::FracBits;
    endfunction

    function longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function void cross_prod(input longint a[3], input longint b[3], output longint o[3]);
        o[0] = qmul(a[1], b[2]) - qmul(a[2], b[1]);
        o[1] = qmul(a[2], b[0]) - qmul(a[0], b[2]);
        o[2] = qmul(a[0], b[1]) - qmul(a[1], b[0]);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Returns 1 for a zero-length vector, which then becomes zero
    function bit unit_vec(input longint c[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned len2;
        longint unsigned r;
        longint unsigned q;
        bit neg[3];
        mx = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            m[i] = neg[i] ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return 1;
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) len2 += m[i] * m[i];
        r = int_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << sft_pkg::FracBits) + r / 2) / r;
            o[i] = clamp16(neg[i] ? -longint'(q) : longint'(q));
        end
        return 0;
    endfunction

    function void note_input(logic [1:0] cmd, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        longint v[3];
        longint res[3];
        longint h[3];
        longint c[3];
        bit d1;
        bit d2;
        bit degen;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        degen = 0;
        for (int i = 0; i < 3; i++) res[i] = 0;
        if (cmd == sft_pkg::CMD_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                nrm[i] = v[i];
                h[i] = 0;
            end
            // helper points down y when the normal has a z part, else down z
            if (v[2] != 0) h[1] = -(64'sd1 <<< sft_pkg::FracBits);
            else h[2] = -(64'sd1 <<< sft_pkg::FracBits);
            cross_prod(nrm, h, c);
            d1 = unit_vec(c, tan_a);
            cross_prod(nrm, tan_a, c);
            d2 = unit_vec(c, tan_b);
            degen = d1 | d2;
            for (int i = 0; i < 3; i++) res[i] = tan_a[i];
            n_load++;
            if (degen) n_degen++;
        end else if (cmd == sft_pkg::CMD_W2L) begin
            for (int i = 0; i < 3; i++) begin
                longint row[3];
                for (int k = 0; k < 3; k++)
                    row[k] = (i == 0) ? tan_a[k] : (i == 1) ? tan_b[k] : nrm[k];
                res[i] = clamp16(qmul(v[0], row[0]) + qmul(v[1], row[1])
                                 + qmul(v[2], row[2]));
            end
        end else if (cmd == sft_pkg::CMD_L2W) begin
            for (int i = 0; i < 3; i++)
                res[i] = clamp16(qmul(tan_a[i], v[0]) + qmul(tan_b[i], v[1])
                                 + qmul(nrm[i], v[2]));
        end
        pending.push_back({res[0][15:0], res[1][15:0], res[2][15:0], degen});
    endfunction

    function void check_result(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic d);
        logic [48:0] e;
        if (pending.size() == 0) begin
            $error("result with no transaction outstanding: %h %h %h %b", x, y, z, d);
            n_err++;
            return;
        end
        e = pending.pop_front();
        n_ok++;
        if (e[48:33] !== x) begin
            $error("out_x expected %h got %h", e[48:33], x);
            n_err++;
        end
        if (e[32:17] !== y) begin
            $error("out_y expected %h got %h", e[32:17], y);
            n_err++;
        end
        if (e[16:1] !== z) begin
            $error("out_z expected %h got %h", e[16:1], z);
            n_err++;
        end
        if (e[0] !== d) begin
            $error("degenerate expected %b got %b", e[0], d);
            n_err++;
        end
    endfunction
endclass

module shading_frame_transform_core_tb;
    import sft_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_cmd = 2'd0;
    logic signed [15:0] i_vec_x = '0;
    logic signed [15:0] i_vec_y = '0;
    logic signed [15:0] i_vec_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic signed [15:0] o_out_z;
    logic o_degenerate;

    // Idle percentages, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    frame_scoreboard frames = new();

    always #1 i_clk = ~i_clk;

    shading_frame_transform_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_degenerate(o_degenerate)
    );

    // Receiver: stall drawn each cycle; a result is taken when valid and
    // not stalled at the edge, so it is checked on that same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            frames.check_result(o_out_x, o_out_y, o_out_z, o_degenerate);
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // One transaction: optional idle gap, then hold valid until taken.
    // Valid stays high across back-to-back transactions (single NBA per edge).
    task automatic send_vec(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        frames.note_input(cmd, x, y, z);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender pauses until every outstanding result has arrived
    task automatic drain();
        go_idle();
        while (frames.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random command mix with extreme, zero and random components; some loads use a flat normal
    task automatic random_item();
        int unsigned pick;
        logic [1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 20) cmd = CMD_LOAD;
        else if (pick < 58) cmd = CMD_W2L;
        else if (pick < 96) cmd = CMD_L2W;
        else cmd = 2'd3;
        if (cmd == CMD_LOAD && $urandom_range(3) == 0)
            // flat normal in xy plane: helper switches to -z
            send_vec(cmd, rand_comp(), rand_comp(), 16'h0000);
        else
            send_vec(cmd, rand_comp(), rand_comp(), rand_comp());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset frame, axis normals, extremes, degenerate loads, unused code
        send_vec(CMD_W2L, 16'h7fff, 16'h8000, 16'h4000);
        send_vec(CMD_L2W, 16'h4000, 16'h4000, 16'h4000);
        send_vec(CMD_LOAD, 16'h0000, 16'h0000, 16'h4000);
        send_vec(CMD_W2L, 16'h4000, 16'hc000, 16'h7fff);
        send_vec(CMD_L2W, 16'h7fff, 16'h8000, 16'h7fff);
        send_vec(CMD_LOAD, 16'h4000, 16'h0000, 16'h0000);
        send_vec(CMD_W2L, 16'h1234, 16'h8000, 16'h0001);
        send_vec(CMD_LOAD, 16'h0000, 16'h0000, 16'h0000); // zero normal
        send_vec(CMD_L2W, 16'h7fff, 16'h7fff, 16'h7fff);
        send_vec(CMD_LOAD, 16'h0000, 16'h4000, 16'h0000); // y-axis normal, helper is -z
        send_vec(CMD_W2L, 16'h7fff, 16'h7fff, 16'h7fff);
        send_vec(CMD_LOAD, 16'h0000, 16'h0001, 16'h0001); // tiny cross product
        send_vec(CMD_LOAD, 16'h7fff, 16'h7fff, 16'h7fff); // non-unit normal
        send_vec(CMD_L2W, 16'h8000, 16'h8000, 16'h8000);
        send_vec(CMD_LOAD, 16'h8000, 16'h8000, 16'h8000);
        send_vec(CMD_W2L, 16'h8000, 16'h7fff, 16'hffff);
        send_vec(2'd3, 16'hffff, 16'hffff, 16'hffff);     // unused code
        send_vec(CMD_LOAD, 16'h2d41, 16'h2d41, 16'hffff);
        send_vec(CMD_L2W, 16'hffff, 16'h0001, 16'h5555);
        drain(); // pressure point: pause until everything is back

        // Random phases: none, sender idle, receiver stall, both, none
        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 56 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 56 : 0;
            if (ph == 3) begin
                send_idle_pct = 6;
                recv_stall_pct = 6;
            end
            for (int n = 0; n < 180; n++) random_item();
        end
        go_idle();
        recv_stall_pct = 0;
        while (frames.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("Covered %0d results, %0d frame loads (%0d degenerate), all idle phases.",
                 frames.n_ok, frames.n_load, frames.n_degen);
        if (frames.n_err == 0 && frames.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: loads are long and stalls stretch them, several times over
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

/* shading_frame_transform_core.f */
rtl/sft_pkg.sv
rtl/sft_datapath.sv
rtl/sft_ctrl.sv
rtl/shading_frame_transform_core.sv
tb/sv/shading_frame_transform_core_tb.sv
